// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the sector store.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LSS_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define LSS_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/lss_pkg.sv =====
// Package with constants, codes and word types of the sector store.
`default_nettype none

package lss_pkg;

   // Store geometry.
   localparam int SLOTS        = 1024;
   localparam int SECTOR_BYTES = 512;
   localparam int SLOT_W       = $clog2(SLOTS);
   localparam int USED_W       = $clog2(SLOTS + 1);
   localparam int ADDR_W       = $clog2(SLOTS * SECTOR_BYTES);

   // Fixed field widths of the request and response words.
   localparam int OP_W   = 2;
   localparam int TAG_W  = 10;
   localparam int OFF_W  = 9;
   localparam int BYTE_W = 8;
   localparam int STAT_W = 2;
   localparam int RSP_USED_W = 11;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
   localparam logic [OP_W-1:0] OP_READ  = 2'd1;
   localparam logic [OP_W-1:0] OP_ERASE = 2'd2;

   // Status codes.
   localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
   localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

   // Data bytes are kept inverted in the array.
   localparam logic [BYTE_W-1:0] INVERT_MASK = 8'hff;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [TAG_W-1:0]  sector_number;
      logic [OFF_W-1:0]  byte_offset;
      logic [BYTE_W-1:0] write_byte;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0]     read_byte;
      logic [STAT_W-1:0]     status;
      logic [RSP_USED_W-1:0] slots_used;
   } rsp_type;

   // One entry of the tag memory.
   typedef struct packed {
      logic             valid;
      logic [TAG_W-1:0] tag;
   } tag_entry_type;

   // Write request into the tag memory.
   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] slot;
      tag_entry_type     entry;
   } tag_wr_type;

   // Outcome of a tag scan.
   typedef struct packed {
      logic              done;
      logic              hit;
      logic [SLOT_W-1:0] slot;
   } scan_res_type;

endpackage

`default_nettype wire

// ===== rtl/lss_byte_ram.sv =====
// Byte array of all slots, one write or one registered read per cycle.
`default_nettype none

module lss_byte_ram
   import lss_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] addr,
   input  wire logic [BYTE_W-1:0] wdata,
   output logic      [BYTE_W-1:0] rdata
);

   logic [BYTE_W-1:0] mem [SLOTS*SECTOR_BYTES];
   logic [BYTE_W-1:0] rdata_ff;

   // Single port with registered read data.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== rtl/lss_tag_scan.sv =====
// Tag memory and the scan unit that searches it from the newest slot down.
`default_nettype none

module lss_tag_scan
   import lss_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire tag_wr_type        tag_wr,
   input  wire logic              scan_go,
   input  wire logic [SLOT_W-1:0] scan_slot,
   input  wire logic [TAG_W-1:0]  scan_key,
   output scan_res_type           scan_res
);

   tag_entry_type     mem [SLOTS];
   tag_entry_type     rdata_ff;

   logic              issue_on_ff, issue_on_in;
   logic [SLOT_W-1:0] issue_ff, issue_in;
   logic              chk_ff, chk_in;
   logic [SLOT_W-1:0] chk_idx_ff, chk_idx_in;
   logic [TAG_W-1:0]  key_ff, key_in;
   logic              match;
   logic              finish;

   // Tag memory: one write port, one registered read port driven by the scan.
   always_ff @(posedge clock) begin
      if (tag_wr.en) begin
         mem[tag_wr.slot] <= tag_wr.entry;
      end
      rdata_ff <= mem[issue_ff];
   end

   // Compare the entry read in the previous cycle against the key.
   assign match  = chk_ff && rdata_ff.valid && (rdata_ff.tag == key_ff);
   assign finish = chk_ff && (match || (chk_idx_ff == '0));

   // Scan sequencer: issue one address per cycle, counting down to slot zero.
   always_comb begin
      issue_on_in = issue_on_ff;
      issue_in    = issue_ff;
      chk_in      = chk_ff;
      chk_idx_in  = chk_idx_ff;
      key_in      = key_ff;
      if (scan_go) begin
         issue_on_in = 1'b1;
         issue_in    = scan_slot;
         chk_in      = 1'b0;
         key_in      = scan_key;
      end else if (finish) begin
         issue_on_in = 1'b0;
         chk_in      = 1'b0;
      end else begin
         chk_in     = issue_on_ff;
         chk_idx_in = issue_ff;
         if (issue_on_ff) begin
            if (issue_ff == '0) begin
               issue_on_in = 1'b0;
            end else begin
               issue_in = issue_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_on_ff <= 1'b0;
         chk_ff      <= 1'b0;
      end else begin
         issue_on_ff <= issue_on_in;
         chk_ff      <= chk_in;
      end
      issue_ff   <= issue_in;
      chk_idx_ff <= chk_idx_in;
      key_ff     <= key_in;
   end

   assign scan_res.done = finish;
   assign scan_res.hit  = match;
   assign scan_res.slot = chk_idx_ff;

endmodule

`default_nettype wire

// ===== rtl/log_structured_sector_store.sv =====
// Append-only sector log: one byte per command, with a newest-first tag scan on reads.
//
// The block takes one command word when start is high and busy is low, and
// answers each command with exactly one response word, shown for a single
// cycle with rsp_strobe high; the receiver cannot stall, so it must take the
// word in that cycle. A byte write or a byte read that touches the byte array
// passes through decode, address, memory access and finish before the
// response. An erase, an unused operation and a command that is rejected or
// ignored skip the array and pass only through decode and finish before the
// response. A read at offset 0 on a non-empty store first scans the tag
// memory from the newest claimed slot down, one entry per cycle through its
// single read port, stopping at the first match, and reads the byte array
// only on a hit. Erase only resets the fill count and the latched read hit,
// so there is no clearing pass after reset or erase.
`default_nettype none

module log_structured_sector_store
   import lss_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_item,
   output logic         rsp_strobe,
   output rsp_type      rsp_item
);

   // Sequencer states.
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_ADDR   = 3'd3;
   localparam logic [2:0] S_MEM    = 3'd4;
   localparam logic [2:0] S_FINISH = 3'd5;

   // Byte array access codes.
   localparam logic [1:0] MEM_NONE  = 2'd0;
   localparam logic [1:0] MEM_WRITE = 2'd1;
   localparam logic [1:0] MEM_READ  = 2'd2;

   logic [2:0]        state_ff, state_in;
   req_type           req_ff, req_in;
   logic [USED_W-1:0] next_free_ff, next_free_in;
   logic              open_sealed_ff, open_sealed_in;
   logic              read_hit_ff, read_hit_in;
   logic [SLOT_W-1:0] latched_ff, latched_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [1:0]        mem_op_ff, mem_op_in;
   logic [STAT_W-1:0] status_ff, status_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   rsp_type           rsp_ff, rsp_in;

   tag_wr_type        tag_wr;
   logic              scan_go;
   scan_res_type      scan_res;
   logic              byte_we;
   logic [BYTE_W-1:0] byte_rdata;

   logic              off_big, off_zero, off_last, store_full;

   // Offset and fill-level decode of the held command.
   assign off_big    = int'(req_ff.byte_offset) >= SECTOR_BYTES;
   assign off_zero   = req_ff.byte_offset == '0;
   assign off_last   = int'(req_ff.byte_offset) == SECTOR_BYTES - 1;
   assign store_full = int'(next_free_ff) >= SLOTS;

   // Command sequencer.
   always_comb begin
      state_in       = state_ff;
      req_in         = req_ff;
      next_free_in   = next_free_ff;
      open_sealed_in = open_sealed_ff;
      read_hit_in    = read_hit_ff;
      latched_in     = latched_ff;
      slot_in        = slot_ff;
      mem_op_in      = mem_op_ff;
      status_in      = status_ff;
      addr_in        = addr_ff;
      rsp_strobe_in  = 1'b0;
      rsp_in         = rsp_ff;
      tag_wr         = '0;
      scan_go        = 1'b0;
      byte_we        = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in   = req_item;
               state_in = S_DECODE;
            end
         end

         S_DECODE: begin
            mem_op_in = MEM_NONE;
            status_in = ST_OK;
            state_in  = S_FINISH;
            unique case (req_ff.op)
               OP_WRITE: begin
                  if (off_big) begin
                     status_in = ST_OK;
                  end else if (off_zero) begin
                     if (store_full) begin
                        status_in = ST_FULL;
                     end else begin
                        // Claim the next free slot and mark it open.
                        slot_in            = next_free_ff[SLOT_W-1:0];
                        next_free_in       = next_free_ff + 1'b1;
                        open_sealed_in     = 1'b0;
                        tag_wr.en          = 1'b1;
                        tag_wr.slot        = next_free_ff[SLOT_W-1:0];
                        tag_wr.entry.valid = 1'b0;
                        tag_wr.entry.tag   = req_ff.sector_number;
                        mem_op_in          = MEM_WRITE;
                        state_in           = S_ADDR;
                     end
                  end else if ((next_free_ff == '0) || open_sealed_ff) begin
                     status_in = store_full ? ST_FULL : ST_OK;
                  end else begin
                     slot_in   = SLOT_W'(next_free_ff - 1'b1);
                     mem_op_in = MEM_WRITE;
                     state_in  = S_ADDR;
                     // The last byte seals the slot with its sector tag.
                     if (off_last) begin
                        open_sealed_in     = 1'b1;
                        tag_wr.en          = 1'b1;
                        tag_wr.slot        = SLOT_W'(next_free_ff - 1'b1);
                        tag_wr.entry.valid = 1'b1;
                        tag_wr.entry.tag   = req_ff.sector_number;
                     end
                  end
               end

               OP_READ: begin
                  if (off_big) begin
                     status_in = ST_OK;
                  end else if (off_zero) begin
                     read_hit_in = 1'b0;
                     if (next_free_ff == '0) begin
                        status_in = ST_NOT_FOUND;
                     end else begin
                        scan_go  = 1'b1;
                        state_in = S_SCAN;
                     end
                  end else if (!read_hit_ff) begin
                     status_in = ST_NOT_FOUND;
                  end else begin
                     slot_in   = latched_ff;
                     mem_op_in = MEM_READ;
                     state_in  = S_ADDR;
                  end
               end

               OP_ERASE: begin
                  next_free_in = '0;
                  read_hit_in  = 1'b0;
                  latched_in   = '0;
               end

               default: begin
                  status_in = ST_OK;
               end
            endcase
         end

         S_SCAN: begin
            if (scan_res.done) begin
               if (scan_res.hit) begin
                  latched_in  = scan_res.slot;
                  read_hit_in = 1'b1;
                  slot_in     = scan_res.slot;
                  mem_op_in   = MEM_READ;
                  state_in    = S_ADDR;
               end else begin
                  status_in = ST_NOT_FOUND;
                  state_in  = S_FINISH;
               end
            end
         end

         S_ADDR: begin
            addr_in  = ADDR_W'(int'(slot_ff) * SECTOR_BYTES + int'(req_ff.byte_offset));
            state_in = S_MEM;
         end

         S_MEM: begin
            byte_we  = mem_op_ff == MEM_WRITE;
            state_in = S_FINISH;
         end

         S_FINISH: begin
            rsp_strobe_in     = 1'b1;
            rsp_in.read_byte  = (mem_op_ff == MEM_READ) ? (byte_rdata ^ INVERT_MASK) : '0;
            rsp_in.status     = status_ff;
            rsp_in.slots_used = RSP_USED_W'(next_free_ff);
            state_in          = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         next_free_ff   <= '0;
         open_sealed_ff <= 1'b0;
         read_hit_ff    <= 1'b0;
         latched_ff     <= '0;
         rsp_strobe_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         next_free_ff   <= next_free_in;
         open_sealed_ff <= open_sealed_in;
         read_hit_ff    <= read_hit_in;
         latched_ff     <= latched_in;
         rsp_strobe_ff  <= rsp_strobe_in;
      end
      req_ff    <= req_in;
      slot_ff   <= slot_in;
      mem_op_ff <= mem_op_in;
      status_ff <= status_in;
      addr_ff   <= addr_in;
      rsp_ff    <= rsp_in;
   end

   // Tag memory with its scan unit.
   lss_tag_scan u_tag_scan (
      .clock     (clock),
      .reset     (reset),
      .tag_wr    (tag_wr),
      .scan_go   (scan_go),
      .scan_slot (SLOT_W'(next_free_ff - 1'b1)),
      .scan_key  (req_ff.sector_number),
      .scan_res  (scan_res)
   );

   // Byte array; bytes are written inverted.
   lss_byte_ram u_byte_ram (
      .clock (clock),
      .we    (byte_we),
      .addr  (addr_ff),
      .wdata (req_ff.write_byte ^ INVERT_MASK),
      .rdata (byte_rdata)
   );

   assign busy       = state_ff != S_IDLE;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

`default_nettype wire

// ===== rtl/lss_checker.sv =====
// Port-level checker of the sector store and its bind to the top level.
`default_nettype none
`include "assert_macros.svh"

module lss_checker
   import lss_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    start,
   input wire logic    busy,
   input wire req_type req_item,
   input wire logic    rsp_strobe,
   input wire rsp_type rsp_item
);

   // A response word only appears once the block is free again.
   `LSS_ASSERT_IMP(a_strobe_idle, clock, reset, rsp_strobe, !busy, "response while busy")

   // An accepted command makes the block busy in the next cycle.
   `LSS_ASSERT_NXT(a_accept_busy, clock, reset, start && !busy, busy, "accept without busy")

   // Each command gives one response word, never two in a row.
   `LSS_ASSERT_NXT(a_single_rsp, clock, reset, rsp_strobe, !rsp_strobe, "repeated response")

   // A failed command never returns data.
   `LSS_ASSERT_IMP(a_fail_no_data, clock, reset, rsp_strobe && (rsp_item.status != ST_OK), rsp_item.read_byte == '0, "data on failed command")

   // An erase is answered with a response word that shows an empty store.
   `LSS_ASSERT_IMP(a_erase_empty, clock, reset, start && !busy && (req_item.op == OP_ERASE), ##3 (rsp_strobe && (rsp_item.slots_used == '0)), "erase did not empty the store")

endmodule

bind log_structured_sector_store lss_checker u_lss_checker (.*);

`default_nettype wire

// ===== dv/log_structured_sector_store_test.sv =====
// Self-checking testbench for the append-only sector log, with a scoreboard that predicts each response word.
import lss_pkg::*;

// Predicts every response word from the accepted command words and checks the block's words.
class sector_log_scoreboard;
   bit [BYTE_W-1:0] image [SLOTS*SECTOR_BYTES];
   bit [TAG_W-1:0]  tags [SLOTS];
   bit              sealed [SLOTS];
   int unsigned     offsets_written [SLOTS][$];
   int unsigned     claimed;
   int unsigned     latched;
   bit              hit;
   rsp_type         awaited [$];
   int unsigned     mismatches;

   function void flag(string what, int unsigned want, int unsigned got);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch in %s: expected %0d, got %0d", what, want, got);
   endfunction

   // Applies one accepted command word to the predicted store and queues its response.
   function void note_command(req_type w);
      rsp_type     want;
      int unsigned slot;
      int unsigned base;
      int unsigned off;
      want = '0;
      off = int'(w.byte_offset);
      case (w.op)
         OP_WRITE: begin
            if (off == 0) begin
               // A first byte claims a fresh slot unless all are taken.
               if (claimed >= SLOTS) begin
                  want.status = ST_FULL;
               end else begin
                  slot = claimed;
                  claimed++;
                  sealed[slot] = 1'b0;
                  offsets_written[slot].delete();
                  offsets_written[slot].push_back(0);
                  image[slot*SECTOR_BYTES] = w.write_byte;
               end
            end else if (claimed == 0 || sealed[claimed-1]) begin
               // Nothing open to write into: the byte is dropped.
               want.status = (claimed >= SLOTS) ? ST_FULL : ST_OK;
            end else begin
               slot = claimed - 1;
               image[slot*SECTOR_BYTES + off] = w.write_byte;
               offsets_written[slot].push_back(off);
               if (off == SECTOR_BYTES - 1) begin
                  tags[slot] = w.sector_number;
                  sealed[slot] = 1'b1;
               end
            end
         end
         OP_READ: begin
            // A first byte looks up the newest sealed slot carrying the sector.
            if (off == 0) begin
               hit = 1'b0;
               for (int unsigned i = 0; i < claimed; i++) begin
                  if (sealed[i] && tags[i] == w.sector_number) begin
                     latched = i;
                     hit = 1'b1;
                  end
               end
            end
            if (!hit) begin
               want.status = ST_NOT_FOUND;
            end else begin
               base = latched * SECTOR_BYTES;
               want.read_byte = image[base + off];
            end
         end
         OP_ERASE: begin
            claimed = 0;
            latched = 0;
            hit = 1'b0;
            sealed = '{default: 1'b0};
         end
         default: begin
         end
      endcase
      want.slots_used = RSP_USED_W'(claimed);
      awaited.push_back(want);
   endfunction

   // Compares one response word, field by field, with the oldest prediction.
   function void check_response(rsp_type got);
      rsp_type want;
      if (awaited.size() == 0) begin
         flag("unexpected response word", 0, got);
      end else begin
         want = awaited.pop_front();
         if (got.read_byte !== want.read_byte)
            flag("read_byte", want.read_byte, got.read_byte);
         if (got.status !== want.status)
            flag("status", want.status, got.status);
         if (got.slots_used !== want.slots_used)
            flag("slots_used", want.slots_used, got.slots_used);
      end
   endfunction

   // A read offset that never touches a byte left unwritten in the latched slot.
   function int unsigned pick_read_offset();
      int unsigned n;
      if (!hit)
         return $urandom_range(1, SECTOR_BYTES - 1);
      n = offsets_written[latched].size();
      return offsets_written[latched][$urandom_range(0, n - 1)];
   endfunction
endclass

module log_structured_sector_store_test;
   localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
   localparam int unsigned STALL_LIMIT = 5000;
   localparam int unsigned TAIL_CYCLES = 20;
   localparam int unsigned MIXED_WORDS = 650;
   localparam int unsigned WORDS_PAST_FULL = 40;
   localparam int unsigned LAST_OFFSET = SECTOR_BYTES - 1;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_strobe;
   rsp_type rsp_item;

   sector_log_scoreboard sb = new();
   int unsigned words_sent;
   int unsigned stalled_cycles;
   bit          steady;

   log_structured_sector_store dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Every response word is checked in the cycle it is shown.
   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         sb.check_response(rsp_item);
   end

   // Ends the run when no word moves on either side for too long.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe) begin
         stalled_cycles <= 0;
      end else if (stalled_cycles >= STALL_LIMIT) begin
         $display("FAIL log_structured_sector_store");
         $finish;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
      end
   end

   // Presents one command word after a random gap and waits until the block takes it.
   task automatic issue(input logic [OP_W-1:0] op, input int unsigned sector,
                        input int unsigned offset, input int unsigned data);
      req_type w;
      int unsigned gap;
      w.op = op;
      w.sector_number = TAG_W'(sector);
      w.byte_offset = OFF_W'(offset);
      w.write_byte = BYTE_W'(data);
      if ($urandom_range(0, 39) == 0)
         steady = !steady;
      gap = steady ? 0 : $urandom_range(0, 14);
      repeat (gap) @(negedge clock);
      start = 1'b1;
      req_item = w;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_command(w);
      words_sent++;
      @(negedge clock);
      start = 1'b0;
   endtask

   // Holds the sender back until every predicted response word has arrived.
   task automatic wait_drained();
      while (sb.awaited.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic int unsigned pick_sector();
      return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 15);
   endfunction

   // Mostly well-formed sector writes and read-backs over a small pool of sectors, plus noise.
   task automatic mixed_traffic(input int unsigned limit);
      int unsigned pick;
      int unsigned sector;
      logic [OP_W-1:0] op;
      while (words_sent < limit) begin
         pick = $urandom_range(0, 99);
         sector = pick_sector();
         if (pick < 38) begin
            issue(OP_WRITE, sector, 0, $urandom);
            repeat ($urandom_range(0, 6))
               issue(OP_WRITE, ($urandom_range(0, 3) == 0) ? pick_sector() : sector,
                     $urandom_range(1, LAST_OFFSET - 1), $urandom);
            if ($urandom_range(0, 4) != 0)
               issue(OP_WRITE, ($urandom_range(0, 9) == 0) ? pick_sector() : sector,
                     LAST_OFFSET, $urandom);
         end else if (pick < 76) begin
            issue(OP_READ, sector, 0, $urandom);
            repeat ($urandom_range(0, 6))
               issue(OP_READ, $urandom, sb.pick_read_offset(), $urandom);
         end else if (pick < 94) begin
            op = OP_W'($urandom_range(0, 3));
            if (op == OP_ERASE && $urandom_range(0, 3) != 0)
               op = OP_SPARE;
            if (op == OP_READ)
               issue(op, sector, ($urandom_range(0, 3) == 0) ? 0 : sb.pick_read_offset(),
                     $urandom);
            else
               issue(op, $urandom, $urandom_range(0, LAST_OFFSET), $urandom);
         end else if (pick < 97) begin
            wait_drained();
         end else begin
            issue(OP_ERASE, $urandom, $urandom, $urandom);
         end
      end
   endtask

   // Claims slots until the store is full, then keeps going for a while against the full store.
   task automatic fill_traffic();
      int unsigned pick;
      int unsigned past_full;
      past_full = 0;
      while (past_full < WORDS_PAST_FULL) begin
         pick = $urandom_range(0, 99);
         if (pick < 86)
            issue(OP_WRITE, $urandom, 0, $urandom);
         else if (pick < 91)
            issue(OP_WRITE, $urandom,
                  ($urandom_range(0, 7) == 0) ? LAST_OFFSET : $urandom_range(1, LAST_OFFSET),
                  $urandom);
         else if (pick < 95)
            issue(OP_READ, $urandom, 0, $urandom);
         else
            issue(OP_READ, $urandom, sb.pick_read_offset(), $urandom);
         if (sb.claimed >= SLOTS)
            past_full++;
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      steady = 1'b0;
      words_sent = 0;
      stalled_cycles = 0;
      repeat (11) @(negedge clock);
      reset = 1'b0;

      // Empty store, stray bytes and the unused operation.
      issue(OP_READ, 0, 0, 8'h00);
      issue(OP_READ, 0, 5, 8'h00);
      issue(OP_WRITE, 0, 7, 8'h81);
      issue(OP_SPARE, 1023, LAST_OFFSET, 8'hff);

      // One full sector life: claim, fill, seal, late write, read back.
      issue(OP_WRITE, 1023, 0, 8'h00);
      issue(OP_WRITE, 1023, 1, 8'hff);
      issue(OP_WRITE, 1023, 255, 8'ha5);
      issue(OP_WRITE, 1023, LAST_OFFSET, 8'h5a);
      issue(OP_WRITE, 1023, 3, 8'h77);
      issue(OP_READ, 1023, 0, 8'h00);
      issue(OP_READ, 1023, LAST_OFFSET, 8'h00);
      issue(OP_READ, 1023, 1, 8'h00);
      issue(OP_READ, 1023, 255, 8'h00);

      // A second sector, then a newer copy of the first that must win the lookup.
      issue(OP_WRITE, 0, 0, 8'h3c);
      issue(OP_WRITE, 0, LAST_OFFSET, 8'hc3);
      issue(OP_WRITE, 1023, 0, 8'h11);
      issue(OP_WRITE, 1023, LAST_OFFSET, 8'h22);
      issue(OP_READ, 1023, 0, 8'h00);
      issue(OP_READ, 1023, LAST_OFFSET, 8'h00);
      issue(OP_READ, 0, 0, 8'h00);
      issue(OP_READ, 512, 0, 8'h00);
      issue(OP_READ, 512, LAST_OFFSET, 8'h00);

      // Erase forgets everything.
      issue(OP_ERASE, 1023, LAST_OFFSET, 8'hff);
      issue(OP_READ, 1023, 0, 8'h00);
      wait_drained();

      mixed_traffic(MIXED_WORDS);
      wait_drained();
      issue(OP_ERASE, 0, 0, 8'h00);
      fill_traffic();
      wait_drained();
      issue(OP_ERASE, 0, 0, 8'h00);
      mixed_traffic(words_sent + 30);

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.awaited.size() == 0)
         $display("PASS log_structured_sector_store");
      else
         $display("FAIL log_structured_sector_store");
      $finish;
   end
endmodule
